[rtl/dol_pkg.sv]
// ============================================================================
// dol_pkg
// Shared types and constants of the ordered key list with move-to-front.
// ============================================================================
package dol_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  // Index and count width: wide enough to hold the capacity itself.
  localparam int IDX_W     = $clog2(CAPACITY + 1);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // Request codes; code 7 is unused and falls to the default arm.
  typedef enum logic [2:0] {
    FN_INS_AT   = 3'd0,
    FN_INS_TOP  = 3'd1,
    FN_INS_BOT  = 3'd2,
    FN_REM_AT   = 3'd3,
    FN_REM_KEY  = 3'd4,
    FN_MOVE_TOP = 3'd5,
    FN_FIND     = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    STAT_DONE   = 3'd0,
    STAT_DUP    = 3'd1,
    STAT_OFFSET = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_NONE   = 3'd4
  } status_t;

  // What a cell loads at the end of the update cycle.
  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_LOAD = 2'd1,
    SEL_PREV = 2'd2,
    SEL_NEXT = 2'd3
  } sel_t;

  typedef struct packed {
    logic    done;
    status_t status;
    idx_t    found_index;
    idx_t    list_count;
  } result_t;

endpackage

[rtl/dol_cell.sv]
// ============================================================================
// dol_cell
// One list position: holds a key, compares it against the request key and
// loads the request key or a neighbor's key when told to.
// ============================================================================
module dol_cell (
  input  logic          clk,
  input  dol_pkg::sel_t sel,
  input  dol_pkg::key_t key,
  input  dol_pkg::key_t prev_entry,
  input  dol_pkg::key_t next_entry,
  input  logic          valid,
  output dol_pkg::key_t entry,
  output logic          match
);

  assign match = valid && (entry == key);

  always_ff @(posedge clk) begin
    case (sel)
      dol_pkg::SEL_LOAD: entry <= key;
      dol_pkg::SEL_PREV: entry <= prev_entry;
      dol_pkg::SEL_NEXT: entry <= next_entry;
      default:           entry <= entry;
    endcase
  end

endmodule

[rtl/dol_ctrl.sv]
// ============================================================================
// dol_ctrl
// Sequencer of the list: latches a request, captures the cell matches, then
// decides status, index and count and tells every cell what to load.
// ============================================================================
module dol_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [2:0]                           func,
  input  dol_pkg::key_t                        item_key,
  input  logic [4:0]                           offset,
  input  logic [dol_pkg::CAPACITY-1:0]         match,
  output logic                                 busy,
  output dol_pkg::key_t                        key,
  output logic [dol_pkg::CAPACITY-1:0]         valid,
  output dol_pkg::sel_t [dol_pkg::CAPACITY-1:0] sel,
  output dol_pkg::result_t                     result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_REM,
    OP_MTF
  } op_t;

  state_t                        state;
  logic [2:0]                    cmd_func;
  dol_pkg::key_t                 cmd_key;
  dol_pkg::idx_t                 cmd_offset;
  logic [dol_pkg::CAPACITY-1:0]  match_q;
  dol_pkg::idx_t                 count;

  logic                          hit;
  dol_pkg::idx_t                 first;
  dol_pkg::idx_t                 loc;
  dol_pkg::idx_t                 ins_pos;
  dol_pkg::status_t              status_next;
  dol_pkg::idx_t                 index_next;
  dol_pkg::idx_t                 count_next;
  op_t                           op;
  dol_pkg::idx_t                 op_pos;
  logic [dol_pkg::CAPACITY-1:0]  load_vec;

  assign busy = (state != S_IDLE);
  assign key  = cmd_key;

  always_comb begin
    for (int i = 0; i < dol_pkg::CAPACITY; i++) begin
      valid[i] = (dol_pkg::IDX_W'(i) < count);
    end
  end

  // Lowest matching position; keys are distinct so at most one bit is set.
  always_comb begin
    first = '0;
    for (int i = dol_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first = dol_pkg::IDX_W'(i);
      end
    end
  end

  assign hit = |match_q;
  assign loc = hit ? first : count;

  always_comb begin
    status_next = dol_pkg::STAT_NONE;
    index_next  = '0;
    count_next  = count;
    op          = OP_NONE;
    op_pos      = '0;
    ins_pos     = '0;
    case (dol_pkg::func_t'(cmd_func))
      dol_pkg::FN_INS_AT, dol_pkg::FN_INS_TOP, dol_pkg::FN_INS_BOT: begin
        if (cmd_func == dol_pkg::FN_INS_AT) begin
          ins_pos = cmd_offset;
        end else if (cmd_func == dol_pkg::FN_INS_TOP) begin
          ins_pos = '0;
        end else begin
          ins_pos = count;
        end
        if (ins_pos > count) begin
          status_next = dol_pkg::STAT_OFFSET;
          index_next  = loc;
        end else if (hit) begin
          status_next = dol_pkg::STAT_DUP;
          index_next  = first;
        end else if (count >= dol_pkg::IDX_W'(dol_pkg::CAPACITY)) begin
          status_next = dol_pkg::STAT_FULL;
          index_next  = count;
        end else begin
          status_next = dol_pkg::STAT_DONE;
          index_next  = ins_pos;
          count_next  = count + 1'b1;
          op          = OP_INS;
          op_pos      = ins_pos;
        end
      end
      dol_pkg::FN_REM_AT: begin
        if (cmd_offset < count) begin
          status_next = dol_pkg::STAT_DONE;
          count_next  = count - 1'b1;
          op          = OP_REM;
          op_pos      = cmd_offset;
        end
      end
      dol_pkg::FN_REM_KEY: begin
        index_next = count;
        if (hit) begin
          status_next = dol_pkg::STAT_DONE;
          count_next  = count - 1'b1;
          index_next  = count - 1'b1;
          op          = OP_REM;
          op_pos      = first;
        end
      end
      dol_pkg::FN_MOVE_TOP: begin
        index_next = loc;
        if (hit) begin
          status_next = dol_pkg::STAT_DONE;
          op          = OP_MTF;
          op_pos      = first;
        end
      end
      dol_pkg::FN_FIND: begin
        index_next  = loc;
        status_next = hit ? dol_pkg::STAT_DONE : dol_pkg::STAT_NONE;
      end
      default: begin
        status_next = dol_pkg::STAT_NONE;
      end
    endcase
  end

  // Per-cell load select, only driven in the update cycle.
  always_comb begin
    for (int i = 0; i < dol_pkg::CAPACITY; i++) begin
      sel[i] = dol_pkg::SEL_HOLD;
      if (state == S_UPD) begin
        case (op)
          OP_INS: begin
            if (dol_pkg::IDX_W'(i) == op_pos) begin
              sel[i] = dol_pkg::SEL_LOAD;
            end else if (dol_pkg::IDX_W'(i) > op_pos) begin
              sel[i] = dol_pkg::SEL_PREV;
            end
          end
          OP_REM: begin
            if ((dol_pkg::IDX_W'(i) >= op_pos) && (i < dol_pkg::CAPACITY - 1)) begin
              sel[i] = dol_pkg::SEL_NEXT;
            end
          end
          OP_MTF: begin
            if (i == 0) begin
              sel[i] = dol_pkg::SEL_LOAD;
            end else if (dol_pkg::IDX_W'(i) <= op_pos) begin
              sel[i] = dol_pkg::SEL_PREV;
            end
          end
          default: sel[i] = dol_pkg::SEL_HOLD;
        endcase
      end
      load_vec[i] = (sel[i] == dol_pkg::SEL_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      result.done <= 1'b0;
    end else begin
      result.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state              <= S_IDLE;
          count              <= count_next;
          result.done        <= 1'b1;
          result.status      <= status_next;
          result.found_index <= index_next;
          result.list_count  <= count_next;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      cmd_func   <= func;
      cmd_key    <= item_key;
      cmd_offset <= offset;
    end
    if (state == S_CMP) begin
      match_q <= match;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dol_pkg::IDX_W'(dol_pkg::CAPACITY))
    else $error("list count above capacity");

  a_done_after_upd: assert property (@(posedge clk) disable iff (rst)
    result.done |-> $past(state == S_UPD))
    else $error("result strobe without an update cycle");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CMP))
    else $error("accepted word did not enter the compare cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> (count == $past(count)) || (count == $past(count) + 1'b1)
                         || (count == $past(count) - 1'b1))
    else $error("count moved by more than one");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $countones(load_vec) <= 1)
    else $error("more than one cell loads the request key");

endmodule

[rtl/dedup_ordered_list.sv]
// ============================================================================
// dedup_ordered_list
// Fixed-capacity ordered list of distinct keys with move-to-front.
// ============================================================================
// A request word is accepted when start is high while busy is low. It then
// passes through a compare state and an update state: in the compare state
// every cell compares its key with the request key and the match vector is
// registered; in the update state the sequencer turns the matches into
// status, index and count and each cell holds, takes a neighbor's key or
// loads the request key at the closing clock edge. The result word appears
// for exactly one cycle with done high, in the cycle after that update, and
// the receiver cannot hold it off; busy is already low in that cycle, so a
// new word may be accepted then. The block thus takes a new word only once
// the last one has passed through the compare and update states, paced by
// the registered match vector that separates the compare and shift steps
// of the cell chain. Entries are never cleared; only positions below the
// count are ever compared or reported, so no clearing pass follows reset.
module dedup_ordered_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  func,
  input  logic [dol_pkg::KEY_WIDTH-1:0] item_key,
  input  logic [4:0]                  offset,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [dol_pkg::IDX_W-1:0]   found_index,
  output logic [dol_pkg::IDX_W-1:0]   list_count
);

  dol_pkg::key_t                          key;
  dol_pkg::key_t [dol_pkg::CAPACITY-1:0]  entry;
  logic [dol_pkg::CAPACITY-1:0]           match;
  logic [dol_pkg::CAPACITY-1:0]           valid;
  dol_pkg::sel_t [dol_pkg::CAPACITY-1:0]  sel;
  dol_pkg::result_t                       result;

  // Sequencer: owns the count and decides what each cell does.
  dol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .item_key (item_key),
    .offset   (offset),
    .match    (match),
    .busy     (busy),
    .key      (key),
    .valid    (valid),
    .sel      (sel),
    .result   (result)
  );

  // The chain of cells. The top cell never takes from above and the bottom
  // cell never takes from below, so those ends feed back their own key.
  for (genvar g = 0; g < dol_pkg::CAPACITY; g++) begin : g_cell
    dol_cell u_cell (
      .clk        (clk),
      .sel        (sel[g]),
      .key        (key),
      .prev_entry ((g == 0) ? entry[g] : entry[(g == 0) ? 0 : g - 1]),
      .next_entry ((g == dol_pkg::CAPACITY - 1) ? entry[g]
                   : entry[(g == dol_pkg::CAPACITY - 1) ? g : g + 1]),
      .valid      (valid[g]),
      .entry      (entry[g]),
      .match      (match[g])
    );
  end

  assign done        = result.done;
  assign status      = result.status;
  assign found_index = result.found_index;
  assign list_count  = result.list_count;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for dedup_ordered_list
// A directed script covers empty-list corner cases, the unused request code,
// duplicates, a full list and offsets past the end. A random stream of
// requests follows, run under three sender idle rates. A behavioral copy of
// the list predicts each result word the script leaves open, and a monitor
// compares each result word with the oldest one owed, field by field.
// ----------------------------------------------------------------------------
module tb;
  import dol_pkg::*;

  localparam int          CLK_HALF   = 6;
  localparam int          RESET_CYC  = 5;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          PHASE_LEN  = 167;
  localparam int          KEY_POOL_N = 24;
  localparam int          DRAIN_CYC  = 8;
  // Code 7 has no operation; the block must answer it without any change.
  localparam logic [2:0]  FN_UNUSED  = 3'd7;

  // One result word: status, index and count after the request.
  typedef struct packed {
    logic [2:0] status;
    idx_t       index;
    idx_t       count;
  } outcome_t;

  // One line of the directed script. When known is set, the expected result
  // word is written into the script instead of being predicted.
  typedef struct packed {
    logic [2:0] fn;
    key_t       key;
    logic [4:0] off;
    logic       known;
    outcome_t   want;
  } script_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] func;
  key_t       item_key;
  logic [4:0] offset;
  logic       done;
  logic [2:0] status;
  idx_t       found_index;
  idx_t       list_count;

  dedup_ordered_list u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .item_key    (item_key),
    .offset      (offset),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .list_count  (list_count)
  );

  // Behavioral copy of the list: shelf[0] is the top entry.
  key_t        shelf [CAPACITY];
  int          shelf_len;
  key_t        key_pool [KEY_POOL_N];
  outcome_t    pending_results [$];
  script_row_t script [$];
  int          errors;
  int          cycles = 0;
  int          sender_idle;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------
  function automatic int position_of(key_t k);
    for (int i = 0; i < shelf_len; i++)
      if (shelf[i] == k) return i;
    return shelf_len;
  endfunction

  task automatic drop_entry(input int p);
    for (int i = p; i + 1 < shelf_len; i++) shelf[i] = shelf[i + 1];
    shelf_len--;
  endtask

  // Insert checks come in a fixed order: offset first, then duplicate, then
  // room. Any failed check leaves the list as it was.
  task automatic place_entry(input key_t k, input int p, output logic [2:0] st);
    if (p > shelf_len) begin
      st = STAT_OFFSET;
    end else if (position_of(k) != shelf_len) begin
      st = STAT_DUP;
    end else if (shelf_len >= CAPACITY) begin
      st = STAT_FULL;
    end else begin
      for (int i = shelf_len; i > p; i--) shelf[i] = shelf[i - 1];
      shelf[p] = k;
      shelf_len++;
      st = STAT_DONE;
    end
  endtask

  // Applies one request to the list copy and returns the result word it owes.
  task automatic apply_request(input logic [2:0] fn, input key_t k, input logic [4:0] off,
                               output outcome_t res);
    int         p;
    logic [2:0] st;
    int         ix;
    st = STAT_NONE;
    ix = 0;
    case (fn)
      FN_INS_AT, FN_INS_TOP, FN_INS_BOT: begin
        p = (fn == FN_INS_AT) ? int'(off) : ((fn == FN_INS_TOP) ? 0 : shelf_len);
        place_entry(k, p, st);
        ix = position_of(k);
      end
      FN_REM_AT: begin
        if (int'(off) < shelf_len) begin
          drop_entry(int'(off));
          st = STAT_DONE;
        end
      end
      FN_REM_KEY: begin
        p = position_of(k);
        if (p < shelf_len) begin
          drop_entry(p);
          st = STAT_DONE;
        end
        ix = position_of(k);
      end
      FN_MOVE_TOP: begin
        // The index reported is where the key sat before the move.
        p = position_of(k);
        ix = p;
        if (p < shelf_len) begin
          drop_entry(p);
          place_entry(k, 0, st);
          st = STAT_DONE;
        end
      end
      FN_FIND: begin
        ix = position_of(k);
        st = (ix < shelf_len) ? STAT_DONE : STAT_NONE;
      end
      default: begin
      end
    endcase
    res.status = st;
    res.index  = idx_t'(ix);
    res.count  = idx_t'(shelf_len);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic script_row_t known_row(logic [2:0] fn, key_t k, logic [4:0] off,
                                            logic [2:0] st, int ix, int cnt);
    script_row_t r;
    r.fn   = fn;
    r.key  = k;
    r.off  = off;
    r.known = 1'b1;
    r.want.status = st;
    r.want.index  = idx_t'(ix);
    r.want.count  = idx_t'(cnt);
    return r;
  endfunction

  function automatic script_row_t open_row(logic [2:0] fn, key_t k, logic [4:0] off);
    script_row_t r;
    r = '0;
    r.fn  = fn;
    r.key = k;
    r.off = off;
    return r;
  endfunction

  // Presents one request word, holds it until the block takes it, and then
  // records the result word that it owes. The sender may idle first.
  task automatic send_word(input logic [2:0] fn, input key_t k, input logic [4:0] off,
                           input logic known, input outcome_t want);
    outcome_t res;
    while ($urandom_range(0, 99) < sender_idle) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    func     <= fn;
    item_key <= k;
    offset   <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(fn, k, off, res);
    pending_results.push_back(known ? want : res);
  endtask

  // Keys come mostly from the list itself or from a small pool, so that
  // duplicates, hits and a full list are frequent; the rest are fresh.
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && shelf_len > 0) return shelf[$urandom_range(0, shelf_len - 1)];
    if (r < 75) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    return key_t'($urandom);
  endfunction

  task automatic send_random_word();
    logic [2:0] fn;
    logic [4:0] off;
    fn = ($urandom_range(0, 99) < 95) ? 3'($urandom_range(0, 6)) : FN_UNUSED;
    if ($urandom_range(0, 99) < 85) off = 5'($urandom_range(0, shelf_len));
    else off = 5'($urandom_range(0, 31));
    send_word(fn, pick_key(), off, 1'b0, '0);
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    func        = '0;
    item_key    = '0;
    offset      = '0;
    errors      = 0;
    shelf_len   = 0;
    sender_idle = 23;
    foreach (shelf[i]) shelf[i] = '0;
    foreach (key_pool[i]) key_pool[i] = key_t'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;

    script = '{
      // Empty list: nothing to find or remove, and offset 1 is past the end.
      known_row(FN_FIND,     32'h0000_0000, 5'd0,  STAT_NONE,   0, 0),
      known_row(FN_REM_AT,   32'h0000_0000, 5'd0,  STAT_NONE,   0, 0),
      known_row(FN_INS_AT,   32'h0000_00A5, 5'd1,  STAT_OFFSET, 0, 0),
      known_row(FN_INS_TOP,  32'hFFFF_FFFF, 5'd0,  STAT_DONE,   0, 1),
      known_row(FN_INS_BOT,  32'h0000_0000, 5'd0,  STAT_DONE,   1, 2),
      known_row(FN_INS_TOP,  32'hFFFF_FFFF, 5'd0,  STAT_DUP,    0, 2),
      known_row(FN_UNUSED,   32'h0000_0000, 5'd31, STAT_NONE,   0, 2),
      known_row(FN_MOVE_TOP, 32'h0000_0000, 5'd0,  STAT_DONE,   1, 2),
      known_row(FN_MOVE_TOP, 32'h1234_5678, 5'd0,  STAT_NONE,   2, 2),
      known_row(FN_REM_KEY,  32'h1234_5678, 5'd0,  STAT_NONE,   2, 2),
      // Fill the list to capacity through all three insert flavors.
      open_row(FN_INS_AT,  32'h8000_0001, 5'd2),
      open_row(FN_INS_AT,  32'h4000_0002, 5'd1),
      open_row(FN_INS_TOP, 32'h2000_0003, 5'd0),
      open_row(FN_INS_BOT, 32'h1000_0004, 5'd0),
      open_row(FN_INS_AT,  32'h0800_0005, 5'd6),
      open_row(FN_INS_AT,  32'h0400_0006, 5'd3),
      open_row(FN_INS_TOP, 32'h0200_0007, 5'd0),
      open_row(FN_INS_BOT, 32'h0100_0008, 5'd0),
      open_row(FN_INS_AT,  32'h0080_0009, 5'd10),
      open_row(FN_INS_AT,  32'h0040_000A, 5'd5),
      open_row(FN_INS_TOP, 32'h0020_000B, 5'd0),
      open_row(FN_INS_BOT, 32'h0010_000C, 5'd0),
      open_row(FN_INS_AT,  32'h0008_000D, 5'd7),
      open_row(FN_INS_AT,  32'h0004_000E, 5'd15),
      // Full list: an in-range offset passes, then the room check fails.
      known_row(FN_INS_AT,   32'h5555_AAAA, 5'd16, STAT_FULL,   16, 16),
      open_row(FN_FIND,      32'hFFFF_FFFF, 5'd0),
      known_row(FN_REM_AT,   32'h0000_0000, 5'd16, STAT_NONE,   0, 16),
      known_row(FN_REM_AT,   32'h0000_0000, 5'd15, STAT_DONE,   0, 15),
      open_row(FN_REM_KEY,   32'h0000_0000, 5'd0)
    };

    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_word(script[i].fn, script[i].key, script[i].off, script[i].known, script[i].want);

    // Three random phases: light sender gaps, heavy gaps, then back to back.
    sender_idle = 23;
    repeat (PHASE_LEN) send_random_word();
    sender_idle = 68;
    repeat (PHASE_LEN) send_random_word();
    sender_idle = 0;
    repeat (PHASE_LEN) send_random_word();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A few more cycles so that a stray result word would still be caught.
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result monitor: a result word is taken at the edge that ends its cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (found_index !== want.index) begin
          $error("found_index: expected %0d, got %0d", want.index, found_index);
          errors++;
        end
        if (list_count !== want.count) begin
          $error("list_count: expected %0d, got %0d", want.count, list_count);
          errors++;
        end
      end
    end
  end

endmodule

[files.f]
rtl/dol_pkg.sv
rtl/dol_cell.sv
rtl/dol_ctrl.sv
rtl/dedup_ordered_list.sv
test/tb.sv
